// ===== rtl/lz11_pkg.sv =====
`default_nettype none

package lz11_pkg;

   // History window and counter widths
   localparam int WINDOW_DEPTH = 4096;
   localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
   localparam int SIZE_BITS    = 24;
   localparam int LEN_BITS     = 17;
   localparam int PART_BITS    = 16;
   localparam int DIST_BITS    = ADDR_BITS + 1;

   // Stream constants
   localparam logic [7:0]          MAGIC_BYTE = 8'h11;
   localparam logic [LEN_BITS-1:0] SHORT_BIAS = 17'h00011;
   localparam logic [LEN_BITS-1:0] LONG_BIAS  = 17'h00111;

   // Request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_DRAIN = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Response status codes
   localparam logic [1:0] STATUS_DATA      = 2'd0;
   localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SIZE = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [3:0] {
      PH_MAGIC,
      PH_SIZE0,
      PH_SIZE1,
      PH_SIZE2,
      PH_FLAG,
      PH_TOKEN,
      PH_LEN_SHORT,
      PH_LEN_LONG_A,
      PH_LEN_LONG_B,
      PH_DIST_LO,
      PH_COPY,
      PH_DONE,
      PH_REJECT
   } phase_type;

   // One output byte or status leaving the parser toward the history stage
   typedef struct packed {
      logic                 valid;
      logic                 from_hist;
      logic                 src_zero;
      logic [ADDR_BITS-1:0] rd_addr;
      logic [ADDR_BITS-1:0] wr_addr;
      logic [7:0]           data;
      logic                 last;
      logic [1:0]           status;
   } emit_type;

endpackage

`default_nettype wire

// ===== rtl/lz11_parser.sv =====
`default_nettype none

module lz11_parser (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 accept,
   input  lz11_pkg::req_type   req,
   output lz11_pkg::emit_type  emit
);
   import lz11_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  write_count_ff, write_count_in;
   logic [SIZE_BITS-1:0]  declared_size_ff, declared_size_in;
   logic [7:0]            flag_bits_ff, flag_bits_in;
   logic [2:0]            flag_index_ff, flag_index_in;
   logic [PART_BITS-1:0]  length_partial_ff, length_partial_in;
   logic [LEN_BITS-1:0]   copy_remaining_ff, copy_remaining_in;
   logic [DIST_BITS-1:0]  copy_distance_ff, copy_distance_in;

   logic [SIZE_BITS-1:0]  wc_next;
   logic                  fin;
   logic [LEN_BITS-1:0]   rem_next;
   logic [SIZE_BITS-1:0]  size_full;
   logic [7:0]            b;
   logic                  token_bit;

   assign b         = req.data_byte;
   assign wc_next   = write_count_ff + 1'b1;
   assign fin       = (wc_next == declared_size_ff);
   assign rem_next  = copy_remaining_ff - 1'b1;
   assign size_full = declared_size_ff | {b, 16'd0};
   assign token_bit = flag_bits_ff[3'd7 - flag_index_ff];

   // Hold parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_MAGIC;
         write_count_ff    <= '0;
         declared_size_ff  <= '0;
         flag_bits_ff      <= '0;
         flag_index_ff     <= '0;
         length_partial_ff <= '0;
         copy_remaining_ff <= '0;
         copy_distance_ff  <= '0;
      end else begin
         phase_ff          <= phase_in;
         write_count_ff    <= write_count_in;
         declared_size_ff  <= declared_size_in;
         flag_bits_ff      <= flag_bits_in;
         flag_index_ff     <= flag_index_in;
         length_partial_ff <= length_partial_in;
         copy_remaining_ff <= copy_remaining_in;
         copy_distance_ff  <= copy_distance_in;
      end
   end

   // Decode one request: next state and the emitted byte
   always_comb begin
      phase_in          = phase_ff;
      write_count_in    = write_count_ff;
      declared_size_in  = declared_size_ff;
      flag_bits_in      = flag_bits_ff;
      flag_index_in     = flag_index_ff;
      length_partial_in = length_partial_ff;
      copy_remaining_in = copy_remaining_ff;
      copy_distance_in  = copy_distance_ff;

      emit           = '0;
      emit.wr_addr   = write_count_ff[ADDR_BITS-1:0];
      emit.rd_addr   = write_count_ff[ADDR_BITS-1:0] - copy_distance_ff[ADDR_BITS-1:0];
      emit.src_zero  = ({{(SIZE_BITS-DIST_BITS){1'b0}}, copy_distance_ff} > write_count_ff);
      emit.last      = fin;
      emit.status    = STATUS_DATA;

      if (accept) begin
         priority case (1'b1)
            req.kind == KIND_START: begin
               phase_in          = PH_MAGIC;
               write_count_in    = '0;
               declared_size_in  = '0;
               flag_bits_in      = '0;
               flag_index_in     = '0;
               length_partial_in = '0;
               copy_remaining_in = '0;
               copy_distance_in  = '0;
            end
            req.kind == KIND_DRAIN: begin
               // Copy one byte out of the history
               if (phase_ff == PH_COPY) begin
                  emit.valid        = 1'b1;
                  emit.from_hist    = 1'b1;
                  write_count_in    = wc_next;
                  copy_remaining_in = rem_next;
                  if (fin) begin
                     phase_in = PH_DONE;
                  end else if (rem_next == '0) begin
                     if (flag_index_ff == 3'd7) begin
                        phase_in = PH_FLAG;
                     end else begin
                        phase_in      = PH_TOKEN;
                        flag_index_in = flag_index_ff + 1'b1;
                     end
                  end
               end
            end
            req.kind == KIND_BYTE: begin
               unique case (phase_ff)
                  PH_MAGIC: begin
                     if (b != MAGIC_BYTE) begin
                        phase_in    = PH_REJECT;
                        emit.valid  = 1'b1;
                        emit.last   = 1'b0;
                        emit.status = STATUS_BAD_MAGIC;
                     end else begin
                        phase_in = PH_SIZE0;
                     end
                  end
                  PH_SIZE0: begin
                     declared_size_in = {16'd0, b};
                     phase_in         = PH_SIZE1;
                  end
                  PH_SIZE1: begin
                     declared_size_in = declared_size_ff | {8'd0, b, 8'd0};
                     phase_in         = PH_SIZE2;
                  end
                  PH_SIZE2: begin
                     declared_size_in = size_full;
                     if (size_full == '0) begin
                        phase_in    = PH_DONE;
                        emit.valid  = 1'b1;
                        emit.last   = 1'b0;
                        emit.status = STATUS_ZERO_SIZE;
                     end else begin
                        phase_in = PH_FLAG;
                     end
                  end
                  PH_FLAG: begin
                     flag_bits_in  = b;
                     flag_index_in = '0;
                     phase_in      = PH_TOKEN;
                  end
                  PH_TOKEN: begin
                     if (!token_bit) begin
                        // Literal: emit at once
                        emit.valid     = 1'b1;
                        emit.data      = b;
                        write_count_in = wc_next;
                        if (fin) begin
                           phase_in = PH_DONE;
                        end else if (flag_index_ff == 3'd7) begin
                           phase_in = PH_FLAG;
                        end else begin
                           phase_in      = PH_TOKEN;
                           flag_index_in = flag_index_ff + 1'b1;
                        end
                     end else if (b[7:4] == 4'd0) begin
                        length_partial_in = {8'd0, b[3:0], 4'd0};
                        phase_in          = PH_LEN_SHORT;
                     end else if (b[7:4] == 4'd1) begin
                        length_partial_in = {b[3:0], 12'd0};
                        phase_in          = PH_LEN_LONG_A;
                     end else begin
                        copy_remaining_in = {13'd0, b[7:4]} + 1'b1;
                        copy_distance_in  = {1'b0, b[3:0], 8'd0};
                        phase_in          = PH_DIST_LO;
                     end
                  end
                  PH_LEN_SHORT: begin
                     copy_remaining_in = {1'b0, length_partial_ff | {12'd0, b[7:4]}}
                                         + SHORT_BIAS;
                     copy_distance_in  = {1'b0, b[3:0], 8'd0};
                     phase_in          = PH_DIST_LO;
                  end
                  PH_LEN_LONG_A: begin
                     length_partial_in = length_partial_ff | {4'd0, b, 4'd0};
                     phase_in          = PH_LEN_LONG_B;
                  end
                  PH_LEN_LONG_B: begin
                     copy_remaining_in = {1'b0, length_partial_ff | {12'd0, b[7:4]}}
                                         + LONG_BIAS;
                     copy_distance_in  = {1'b0, b[3:0], 8'd0};
                     phase_in          = PH_DIST_LO;
                  end
                  PH_DIST_LO: begin
                     copy_distance_in = (copy_distance_ff | {5'd0, b}) + 1'b1;
                     phase_in         = PH_COPY;
                  end
                  default: begin
                     // Copy, done and reject drop compressed bytes
                  end
               endcase
            end
            default: begin
               // Unused kind: drop
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/lz11_stream_decompressor_unit.sv =====
`default_nettype none

// LZ11 stream decompressor. Send a start request (kind 2), then the compressed
// stream one byte per request (kind 0): magic 0x11, 24-bit little-endian size,
// then flag bytes and tokens. Literals come back at once; a back-reference
// produces nothing until drain requests (kind 1) arrive, each returning one
// copied byte. The final byte carries last; a bad magic or a zero size gives a
// single status response. The block takes one request per clock while
// req_stall is low: the parser updates its state on the accepting edge, the
// 4096-byte history RAM is read on that edge and its data used in the next
// cycle, with the byte written on that same edge forwarded around the RAM.
// Responses pass through a 4-entry output queue, and req_stall rises only
// when that queue backs up. The history needs no clearing after reset: a
// reference before the start of the stream returns zero, not the RAM data.

module lz11_stream_decompressor_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  lz11_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output lz11_pkg::rsp_type  rsp_payload
);
   import lz11_pkg::*;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   logic      accept;
   emit_type  emit;

   // History stage
   logic                 s2_valid_ff;
   emit_type             s2_ff;
   logic [7:0]           rd_data_ff;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [7:0]           fwd_byte_ff;
   logic [7:0]           s2_byte;
   logic                 s2_write;
   logic [7:0]           history [WINDOW_DEPTH];

   // Output queue
   rsp_type              queue [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 push, pop;
   rsp_type              push_item;

   assign req_stall = ({1'b0, count_ff} + {{(QPTR_BITS+1){1'b0}}, s2_valid_ff})
                      > (QPTR_BITS+2)'(QUEUE_DEPTH - 1);
   assign accept    = req_valid && !req_stall;

   lz11_parser u_parser (
      .clock (clock),
      .reset (reset),
      .accept(accept),
      .req   (req_payload),
      .emit  (emit)
   );

   // Advance the parser output into the history stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= emit.valid;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff       <= emit;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_byte_ff <= s2_byte;
   end

   // Select the output byte: literal, zero before start, forwarded or RAM data
   always_comb begin
      if (!s2_ff.from_hist) begin
         s2_byte = s2_ff.data;
      end else if (s2_ff.src_zero) begin
         s2_byte = 8'd0;
      end else if (fwd_hit_ff) begin
         s2_byte = fwd_byte_ff;
      end else begin
         s2_byte = rd_data_ff;
      end
   end

   assign s2_write   = s2_valid_ff && (s2_ff.status == STATUS_DATA);
   assign fwd_hit_in = s2_write && (s2_ff.wr_addr == emit.rd_addr);

   // History RAM: write the emitted byte, read the copy source
   always_ff @(posedge clock) begin
      if (s2_write) begin
         history[s2_ff.wr_addr] <= s2_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.valid) begin
         rd_data_ff <= history[emit.rd_addr];
      end
   end

   // Queue responses
   assign push               = s2_valid_ff;
   assign pop                = rsp_valid && !rsp_stall;
   assign push_item.out_byte = s2_byte;
   assign push_item.last     = s2_ff.last;
   assign push_item.status   = s2_ff.status;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue[wr_ptr_ff] <= push_item;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== tb/lz11_stream_decompressor_unit_tb.sv =====
`timescale 1ns / 1ps

module lz11_stream_decompressor_unit_tb;
   import lz11_pkg::*;

   localparam logic [1:0] KIND_RESERVED = 2'd3;
   localparam int ITEM_TARGET  = 1850;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;

   // Expected-output tracker: mirrors the decoder state and queues its output bytes
   class lz11_scoreboard;
      logic [7:0]          hist_mem [WINDOW_DEPTH];
      logic [SIZE_BITS-1:0] out_count;
      logic [SIZE_BITS-1:0] target_size;
      phase_type           parse_state;
      logic [7:0]          flag_byte;
      logic [3:0]          flag_pos;
      logic [LEN_BITS-1:0] len_accum;
      logic [LEN_BITS-1:0] copy_left;
      logic [DIST_BITS-1:0] copy_back;
      rsp_type             expected_bytes [$];
      int                  error_count;

      function new();
         for (int i = 0; i < WINDOW_DEPTH; i++) hist_mem[i] = 8'h00;
         error_count = 0;
         restart();
      endfunction

      function void restart();
         out_count   = '0;
         target_size = '0;
         parse_state = PH_MAGIC;
         flag_byte   = '0;
         flag_pos    = '0;
         len_accum   = '0;
         copy_left   = '0;
         copy_back   = '0;
      endfunction

      function bit token_is_reference();
         return flag_byte[3'd7 - flag_pos[2:0]];
      endfunction

      function void advance_token();
         flag_pos    = flag_pos + 4'd1;
         parse_state = (flag_pos >= 4'd8) ? PH_FLAG : PH_TOKEN;
      endfunction

      // Store one decoded byte in the window and queue it as an expected output
      function void emit_byte(logic [7:0] value);
         rsp_type res;
         hist_mem[out_count[ADDR_BITS-1:0]] = value;
         out_count    = out_count + 1'b1;
         res.out_byte = value;
         res.last     = (out_count == target_size);
         res.status   = STATUS_DATA;
         expected_bytes.push_back(res);
         if (res.last) parse_state = PH_DONE;
      endfunction

      function void push_status(logic [1:0] code);
         rsp_type res;
         res.out_byte = 8'h00;
         res.last     = 1'b0;
         res.status   = code;
         expected_bytes.push_back(res);
      endfunction

      // Advance the decoder by one accepted request
      function void apply_request(req_type r);
         logic [7:0]           b;
         logic [ADDR_BITS-1:0] rd_addr;
         logic [7:0]           src;
         b = r.data_byte;
         if (r.kind == KIND_START) begin
            restart();
         end else if (r.kind == KIND_DRAIN) begin
            if (parse_state == PH_COPY) begin
               rd_addr = out_count[ADDR_BITS-1:0] - copy_back[ADDR_BITS-1:0];
               src = ({11'd0, copy_back} > out_count) ? 8'h00 : hist_mem[rd_addr];
               copy_left = copy_left - 1'b1;
               emit_byte(src);
               if (parse_state != PH_DONE && copy_left == '0) advance_token();
            end
         end else if (r.kind == KIND_BYTE) begin
            case (parse_state)
               PH_MAGIC: begin
                  if (b != MAGIC_BYTE) begin
                     parse_state = PH_REJECT;
                     push_status(STATUS_BAD_MAGIC);
                  end else begin
                     parse_state = PH_SIZE0;
                  end
               end
               PH_SIZE0: begin
                  target_size = {16'h0000, b};
                  parse_state = PH_SIZE1;
               end
               PH_SIZE1: begin
                  target_size[15:8] = b;
                  parse_state = PH_SIZE2;
               end
               PH_SIZE2: begin
                  target_size[23:16] = b;
                  if (target_size == '0) begin
                     parse_state = PH_DONE;
                     push_status(STATUS_ZERO_SIZE);
                  end else begin
                     parse_state = PH_FLAG;
                  end
               end
               PH_FLAG: begin
                  flag_byte   = b;
                  flag_pos    = '0;
                  parse_state = PH_TOKEN;
               end
               PH_TOKEN: begin
                  if (!token_is_reference()) begin
                     emit_byte(b);
                     if (parse_state != PH_DONE) advance_token();
                  end else if (b[7:4] == 4'h0) begin
                     len_accum   = {9'd0, b[3:0], 4'h0};
                     parse_state = PH_LEN_SHORT;
                  end else if (b[7:4] == 4'h1) begin
                     len_accum   = {1'b0, b[3:0], 12'h000};
                     parse_state = PH_LEN_LONG_A;
                  end else begin
                     copy_left   = {13'd0, b[7:4]} + 1'b1;
                     copy_back   = {1'b0, b[3:0], 8'h00};
                     parse_state = PH_DIST_LO;
                  end
               end
               PH_LEN_SHORT: begin
                  copy_left   = (len_accum | {13'd0, b[7:4]}) + SHORT_BIAS;
                  copy_back   = {1'b0, b[3:0], 8'h00};
                  parse_state = PH_DIST_LO;
               end
               PH_LEN_LONG_A: begin
                  len_accum   = len_accum | {5'd0, b, 4'h0};
                  parse_state = PH_LEN_LONG_B;
               end
               PH_LEN_LONG_B: begin
                  copy_left   = (len_accum | {13'd0, b[7:4]}) + LONG_BIAS;
                  copy_back   = {1'b0, b[3:0], 8'h00};
                  parse_state = PH_DIST_LO;
               end
               PH_DIST_LO: begin
                  copy_back   = (copy_back | {5'd0, b}) + 1'b1;
                  parse_state = PH_COPY;
               end
               default: ;
            endcase
         end
      endfunction

      // Compare one accepted output against the oldest expected byte
      function void compare_output(rsp_type actual);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            $error("unexpected output: out_byte %02h last %0b status %0d",
                   actual.out_byte, actual.last, actual.status);
            error_count++;
            return;
         end
         want = expected_bytes.pop_front();
         if (actual.out_byte !== want.out_byte) begin
            $error("out_byte mismatch: expected %02h, got %02h", want.out_byte, actual.out_byte);
            error_count++;
         end
         if (actual.last !== want.last) begin
            $error("last mismatch: expected %0b, got %0b", want.last, actual.last);
            error_count++;
         end
         if (actual.status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, actual.status);
            error_count++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   lz11_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int request_count;
   int quiet_cycles;

   lz11_stream_decompressor_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Stall the output channel at random
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Check every accepted output
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.compare_output(rsp_payload);
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("lz11_stream_decompressor_unit_tb failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drive one request; entered and left at a falling edge
   task automatic send_request(input logic [1:0] kind, input logic [7:0] value,
                               input bit counted);
      req_type item;
      item.kind      = kind;
      item.data_byte = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.apply_request(item);
      if (counted) request_count++;
      @(negedge clock);
   endtask

   // Send one back-reference token in short, medium or long form
   task automatic send_reference();
      int          span;
      int          back_dist;
      int          form;
      logic [11:0] dcode;
      logic [15:0] len_code;
      logic [3:0]  nib;
      span = (sb.out_count > 24'd4096) ? 4096 : int'(sb.out_count);
      if (span != 0 && $urandom_range(9) < 8) begin
         back_dist = $urandom_range(1) ? $urandom_range(1, (span < 16) ? span : 16)
                                       : $urandom_range(1, span);
      end else begin
         back_dist = $urandom_range(1, 4096);
      end
      dcode    = 12'(back_dist - 1);
      len_code = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
      nib      = 4'($urandom_range(15, 2));
      form     = $urandom_range(99);
      if (form < 60) begin
         send_request(KIND_BYTE, {nib, dcode[11:8]}, 1'b1);
      end else if (form < 85) begin
         send_request(KIND_BYTE, {4'h0, len_code[7:4]}, 1'b1);
         send_request(KIND_BYTE, {len_code[3:0], dcode[11:8]}, 1'b1);
      end else begin
         send_request(KIND_BYTE, {4'h1, len_code[15:12]}, 1'b1);
         send_request(KIND_BYTE, len_code[11:4], 1'b1);
         send_request(KIND_BYTE, {len_code[3:0], dcode[11:8]}, 1'b1);
      end
      send_request(KIND_BYTE, dcode[7:0], 1'b1);
   endtask

   // Send one stream, mostly well formed, with occasional ignored noise
   task automatic run_stream();
      int          pick;
      int          size;
      logic [7:0]  b;
      send_request(KIND_START, 8'($urandom), 1'b1);
      pick = $urandom_range(99);
      if (pick < 5) begin
         b = 8'($urandom);
         if (b == MAGIC_BYTE) b = 8'h10;
         send_request(KIND_BYTE, b, 1'b1);
         repeat ($urandom_range(3)) send_request(KIND_BYTE, 8'($urandom), 1'b0);
         return;
      end
      if (pick < 9) size = 0;
      else if (pick < 92) size = $urandom_range(1, 40);
      else size = $urandom_range(41, 400);
      send_request(KIND_BYTE, MAGIC_BYTE, 1'b1);
      send_request(KIND_BYTE, size[7:0], 1'b1);
      send_request(KIND_BYTE, size[15:8], 1'b1);
      send_request(KIND_BYTE, size[23:16], 1'b1);
      while (sb.parse_state != PH_DONE) begin
         // abandon the stream now and then
         if ($urandom_range(199) == 0) begin
            send_request(KIND_START, 8'($urandom), 1'b1);
            return;
         end
         // drop in an ignored request now and then
         if ($urandom_range(99) < 4) begin
            case ($urandom_range(2))
               0: send_request(KIND_RESERVED, 8'($urandom), 1'b0);
               1: if (sb.parse_state != PH_COPY)
                     send_request(KIND_DRAIN, 8'($urandom), 1'b0);
               default: if (sb.parse_state == PH_COPY)
                     send_request(KIND_BYTE, 8'($urandom), 1'b0);
            endcase
         end
         case (sb.parse_state)
            PH_COPY:  send_request(KIND_DRAIN, 8'($urandom), 1'b1);
            PH_FLAG:  send_request(KIND_BYTE, 8'($urandom), 1'b1);
            PH_TOKEN: begin
               if (sb.token_is_reference()) send_reference();
               else send_request(KIND_BYTE, 8'($urandom), 1'b1);
            end
            default: ;
         endcase
      end
      repeat ($urandom_range(2)) send_request(KIND_BYTE, 8'($urandom), 1'b0);
   endtask

   initial begin
      sb             = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      rsp_stall      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      request_count  = 0;
      quiet_cycles   = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reserved kind and drain with no copy pending, both dropped
      send_request(KIND_RESERVED, 8'hFF, 1'b0);
      send_request(KIND_DRAIN, 8'h00, 1'b0);
      // bad magic, then a byte ignored after the reject
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, MAGIC_BYTE, 1'b0);
      // declared size zero, then a byte ignored after the end
      send_request(KIND_START, 8'h00, 1'b1);
      send_request(KIND_BYTE, MAGIC_BYTE, 1'b1);
      repeat (3) send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'hFF, 1'b0);
      // six bytes: literal, far reference before start, literal, medium reference
      send_request(KIND_START, 8'hFF, 1'b1);
      send_request(KIND_BYTE, MAGIC_BYTE, 1'b1);
      send_request(KIND_BYTE, 8'h06, 1'b1);
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h50, 1'b1);
      send_request(KIND_BYTE, 8'hFF, 1'b1);
      send_request(KIND_BYTE, 8'h2F, 1'b1);
      send_request(KIND_BYTE, 8'hFF, 1'b1);
      send_request(KIND_DRAIN, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h33, 1'b0);
      send_request(KIND_DRAIN, 8'hFF, 1'b1);
      send_request(KIND_DRAIN, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h80, 1'b1);
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_BYTE, 8'h00, 1'b1);
      send_request(KIND_DRAIN, 8'h00, 1'b1);
      send_request(KIND_DRAIN, 8'h00, 1'b0);

      // random streams across the idle and stall phases
      while (request_count < ITEM_TARGET) begin
         if (request_count < ITEM_TARGET / 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if (request_count < ITEM_TARGET / 2) begin
            send_idle_pct  = 70;
            recv_stall_pct = 0;
         end else if (request_count < 3 * ITEM_TARGET / 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 70;
         end else begin
            send_idle_pct  = 19;
            recv_stall_pct = 19;
         end
         run_stream();
      end

      // drain outstanding outputs, then hold for late extras
      req_valid      <= 1'b0;
      recv_stall_pct = 0;
      while (sb.expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.error_count == 0) begin
         $display("lz11_stream_decompressor_unit_tb passed");
      end else begin
         $display("lz11_stream_decompressor_unit_tb failed");
      end
      $finish;
   end

endmodule
